@@ hw/rtl/fcdma_pkg.sv @@
// fcdma_pkg: shared constants, operation codes and types of the dma controller
// no dependencies
package fcdma_pkg;

    localparam int DEF_CHANNELS   = 4;
    localparam int DEF_FIFO_BURST = 112;

    localparam logic [2:0] OP_WR_SRC  = 3'd0;
    localparam logic [2:0] OP_WR_DST  = 3'd1;
    localparam logic [2:0] OP_WR_CTL  = 3'd2;
    localparam logic [2:0] OP_TRIGGER = 3'd3;
    localparam logic [2:0] OP_DISABLE = 3'd4;
    localparam logic [2:0] OP_STEP    = 3'd5;

    localparam logic [2:0] MODE_IMMEDIATE = 3'd0;
    localparam logic [2:0] MODE_FIFO      = 3'd7;

    localparam logic [31:0] ADDR_MASK_FULL = 32'h0FFF_FFFF;
    localparam logic [31:0] ADDR_MASK_RED  = 32'h07FF_FFFF;
    localparam logic [31:0] CTL_MASK_RED3  = 32'hF7E0_FFFF;
    localparam logic [31:0] CTL_MASK_RED   = 32'hF7E0_3FFF;

    typedef struct packed {
        logic [2:0]  operation;
        logic [1:0]  channel;
        logic [31:0] write_mask;
        logic [31:0] write_value;
        logic [2:0]  event_mode;
        logic [3:0]  channel_set;
        logic        fifo_half_empty;
    } req_t;

    typedef struct packed {
        logic        copy_valid;
        logic [31:0] copy_source;
        logic [31:0] copy_dest;
        logic        copy_is_word;
        logic        irq_valid;
        logic [1:0]  irq_channel;
        logic [3:0]  active_channels;
    } rsp_t;

endpackage

@@ hw/rtl/fcdma_if.sv @@
// fcdma_if: valid/ready channel carrying one word of a given payload type
// no dependencies; the payload type is a parameter
interface fcdma_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/fcdma_core.sv @@
// fcdma_core: channel registers and combinational processing of one request word
// depends on fcdma_pkg
module fcdma_core #(
    parameter int CHANNELS   = fcdma_pkg::DEF_CHANNELS,
    parameter int FIFO_BURST = fcdma_pkg::DEF_FIFO_BURST
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cpu_select,
    input  logic          fire,
    input  fcdma_pkg::req_t req,
    output fcdma_pkg::rsp_t rsp
);
    import fcdma_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [27:0] src_reg [CHANNELS];
    logic [27:0] dst_reg [CHANNELS];
    logic [31:0] ctl_reg [CHANNELS];
    logic [31:0] scur_reg [CHANNELS];
    logic [31:0] dcur_reg [CHANNELS];
    logic [20:0] left_reg [CHANNELS];
    logic [CHANNELS-1:0] act_reg;
    logic [6:0]  burst_reg;
    logic [CW-1:0] cur_reg;
    logic        prog_reg;

    logic [27:0] src_next [CHANNELS];
    logic [27:0] dst_next [CHANNELS];
    logic [31:0] ctl_next [CHANNELS];
    logic [31:0] scur_next [CHANNELS];
    logic [31:0] dcur_next [CHANNELS];
    logic [20:0] left_next [CHANNELS];
    logic [CHANNELS-1:0] act_next;
    logic [6:0]  burst_next;
    logic [CW-1:0] cur_next;
    logic        prog_next;

    // next state and result for the current request
    always_comb
    begin
        logic [31:0] m;
        logic [31:0] oldc;
        logic [31:0] nowc;
        logic        found;
        logic [CW-1:0] ch;
        logic [31:0] cnt;
        logic [2:0]  md;
        logic [1:0]  ds;
        logic [1:0]  ss;
        logic [31:0] sz;
        logic [20:0] nl;
        logic        hit;
        logic        done;
        logic        in_rng;
        src_next  = src_reg;
        dst_next  = dst_reg;
        ctl_next  = ctl_reg;
        scur_next = scur_reg;
        dcur_next = dcur_reg;
        left_next = left_reg;
        act_next  = act_reg;
        burst_next = burst_reg;
        cur_next  = cur_reg;
        prog_next = prog_reg;
        rsp = '0;
        m = '0; oldc = '0; nowc = '0; found = 1'b0; ch = '0;
        cnt = '0; md = '0; ds = '0; ss = '0; sz = '0; nl = '0;
        hit = 1'b0; done = 1'b0;
        in_rng = ({2'b0, req.channel} < 4'(CHANNELS));
        case (req.operation)
            OP_WR_SRC:
            begin
                if (in_rng)
                begin
                    m = req.write_mask & ((!cpu_select || req.channel != 2'd0) ?
                        ADDR_MASK_FULL : ADDR_MASK_RED);
                    src_next[CW'(req.channel)] = (src_reg[CW'(req.channel)] & ~m[27:0])
                        | (req.write_value[27:0] & m[27:0]);
                end
            end
            OP_WR_DST:
            begin
                if (in_rng)
                begin
                    m = req.write_mask & ((!cpu_select || req.channel == 2'd3) ?
                        ADDR_MASK_FULL : ADDR_MASK_RED);
                    dst_next[CW'(req.channel)] = (dst_reg[CW'(req.channel)] & ~m[27:0])
                        | (req.write_value[27:0] & m[27:0]);
                end
            end
            OP_WR_CTL:
            begin
                if (in_rng)
                begin
                    ch = CW'(req.channel);
                    m = req.write_mask;
                    if (cpu_select)
                        m = m & ((req.channel == 2'd3) ? CTL_MASK_RED3 : CTL_MASK_RED);
                    oldc = ctl_reg[ch];
                    nowc = (oldc & ~m) | (req.write_value & m);
                    ctl_next[ch] = nowc;
                    if (!nowc[31] || nowc[29:27] != oldc[29:27])
                    begin
                        act_next[ch] = 1'b0;
                        if (prog_reg && cur_reg == ch)
                            prog_next = 1'b0;
                    end
                    if (nowc[31] && nowc[29:27] == MODE_FIFO && req.fifo_half_empty)
                        act_next[ch] = 1'b1;
                    if (!oldc[31] && nowc[31])
                    begin
                        dcur_next[ch] = {4'd0, dst_reg[ch]};
                        scur_next[ch] = {4'd0, src_reg[ch]};
                        left_next[ch] = nowc[20:0];
                        if (nowc[29:27] == MODE_IMMEDIATE)
                            act_next[ch] = 1'b1;
                    end
                end
            end
            OP_TRIGGER, OP_DISABLE:
            begin
                for (int i = 0; i < CHANNELS && i < 4; i++)
                begin
                    if (cpu_select)
                        hit = !req.event_mode[2] &&
                              ctl_reg[i][29:27] == {req.event_mode[1:0], 1'b0};
                    else
                        hit = ctl_reg[i][29:27] == req.event_mode;
                    if (req.channel_set[i] && ctl_reg[i][31] && hit)
                        act_next[i] = (req.operation == OP_TRIGGER);
                end
            end
            OP_STEP:
            begin
                found = prog_reg;
                ch = cur_reg;
                if (!prog_reg)
                begin
                    for (int i = CHANNELS - 1; i >= 0; i--)
                    begin
                        if (act_reg[i])
                        begin
                            found = 1'b1;
                            ch = CW'(i);
                        end
                    end
                    if (found)
                    begin
                        act_next[ch] = 1'b0;
                        cur_next = ch;
                        burst_next = '0;
                        prog_next = 1'b1;
                    end
                end
                if (found)
                begin
                    cnt = ctl_reg[ch];
                    md = cnt[29:27];
                    ds = cnt[22:21];
                    ss = cnt[24:23];
                    sz = cnt[26] ? 32'd4 : 32'd2;
                    nl = left_reg[ch];
                    done = 1'b1;
                    if (left_reg[ch] != '0)
                    begin
                        rsp.copy_valid = 1'b1;
                        rsp.copy_source = scur_reg[ch];
                        rsp.copy_dest = dcur_reg[ch];
                        rsp.copy_is_word = cnt[26];
                        if (ss == 2'd0) scur_next[ch] = scur_reg[ch] + sz;
                        else if (ss == 2'd1) scur_next[ch] = scur_reg[ch] - sz;
                        if (ds == 2'd0 || ds == 2'd3) dcur_next[ch] = dcur_reg[ch] + sz;
                        else if (ds == 2'd1) dcur_next[ch] = dcur_reg[ch] - sz;
                        nl = left_reg[ch] - 21'd1;
                        left_next[ch] = nl;
                        if (md == MODE_FIFO)
                            burst_next = (prog_reg ? burst_reg : 7'd0) + 7'd1;
                        if (nl != '0 && !(md == MODE_FIFO &&
                            burst_next >= 7'(FIFO_BURST)))
                            done = 1'b0;
                    end
                    if (done)
                    begin
                        prog_next = 1'b0;
                        if (md == MODE_FIFO && req.fifo_half_empty)
                            act_next[ch] = 1'b1;
                        if (!(md == MODE_FIFO && nl != '0))
                        begin
                            if (cnt[25] && md != MODE_IMMEDIATE)
                            begin
                                left_next[ch] = cnt[20:0];
                                if (ds == 2'd3)
                                    dcur_next[ch] = {4'd0, dst_reg[ch]};
                            end
                            else
                            begin
                                ctl_next[ch] = cnt & 32'h7FFF_FFFF;
                                act_next[ch] = 1'b0;
                            end
                            if (cnt[30])
                            begin
                                rsp.irq_valid = 1'b1;
                                rsp.irq_channel = 2'(ch);
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        rsp.active_channels = 4'(act_next);
    end

    // channel state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                src_reg[i] <= '0; dst_reg[i] <= '0; ctl_reg[i] <= '0;
                scur_reg[i] <= '0; dcur_reg[i] <= '0; left_reg[i] <= '0;
            end
            act_reg <= '0;
            burst_reg <= '0;
            cur_reg <= '0;
            prog_reg <= 1'b0;
        end
        else if (fire)
        begin
            src_reg <= src_next; dst_reg <= dst_next; ctl_reg <= ctl_next;
            scur_reg <= scur_next; dcur_reg <= dcur_next; left_reg <= left_next;
            act_reg <= act_next;
            burst_reg <= burst_next;
            cur_reg <= cur_next;
            prog_reg <= prog_next;
        end
    end

endmodule

@@ hw/rtl/four_channel_dma_controller.sv @@
// four_channel_dma_controller: top level with input register and result skid
// depends on fcdma_pkg, fcdma_if and fcdma_core
//
// Usage: request words arrive on the in channel (register writes, trigger,
// disable or step). Each request yields exactly one result word on the out
// channel: a copy request for the served channel, an end-of-transfer
// interrupt and the active channel bits after the request.
// cpu_select must be written through cfg_we/cfg_data only while the block is
// idle; the block itself does not enforce this. A request is registered on
// acceptance, processed by the single-pass core and lands in the result
// register, or in the skid register while the output stalls. Throughput: one
// word per cycle while the output does not stall; the result register plus a
// one-word skid buffer keeps the input ready while a single result waits.
// Reset clears all channel registers, the active bits and the pipeline.
// When the receiver stalls, results collect in the output and skid
// registers and ready drops once both are full with a request in flight.
module four_channel_dma_controller #(
    parameter int CHANNELS   = fcdma_pkg::DEF_CHANNELS,
    parameter int FIFO_BURST = fcdma_pkg::DEF_FIFO_BURST
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_data,
    fcdma_if.sink   in,
    fcdma_if.source out
);
    import fcdma_pkg::*;

    logic cpu_reg;
    req_t req_reg;
    logic req_vld_reg;
    rsp_t out_reg;
    logic out_vld_reg;
    rsp_t skid_reg;
    logic skid_vld_reg;
    rsp_t core_rsp;
    logic proc;
    logic out_free;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cpu_reg <= 1'b0;
        else if (cfg_we)
            cpu_reg <= cfg_data;
    end

    // processing advances when the result has somewhere to go
    assign out_free = !skid_vld_reg;
    assign proc = req_vld_reg && out_free;
    assign in.ready = !req_vld_reg || out_free;

    fcdma_core #(.CHANNELS(CHANNELS), .FIFO_BURST(FIFO_BURST)) u_core (
        .clk(clk), .rst_n(rst_n), .cpu_select(cpu_reg), .fire(proc),
        .req(req_reg), .rsp(core_rsp)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_vld_reg <= 1'b0;
        else if (in.ready)
            req_vld_reg <= in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in.valid && in.ready)
            req_reg <= in.data;
    end

    // result register and skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
            out_vld_reg <= 1'b0;
            skid_reg <= '0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (!out_vld_reg || out.ready)
            begin
                if (skid_vld_reg)
                begin
                    out_reg <= skid_reg;
                    out_vld_reg <= 1'b1;
                    skid_vld_reg <= 1'b0;
                end
                else
                begin
                    out_reg <= core_rsp;
                    out_vld_reg <= proc;
                end
            end
            else if (proc)
            begin
                skid_reg <= core_rsp;
                skid_vld_reg <= 1'b1;
            end
        end
    end

    assign out.valid = out_vld_reg;
    assign out.data = out_reg;

endmodule

@@ hw/rtl/fcdma_checker.sv @@
// fcdma_checker: port-level assertions for the dma controller
// depends on fcdma_pkg; bound to four_channel_dma_controller
module fcdma_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input fcdma_pkg::rsp_t out_data
);
    import fcdma_pkg::*;

    // a copy request never comes without valid addresses zeroed otherwise
    a_copy_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.copy_valid |-> out_data.copy_source == '0
        && out_data.copy_dest == '0 && !out_data.copy_is_word)
        else $error("copy fields set without copy");

    // interrupt channel zero without interrupt
    a_irq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.irq_valid |-> out_data.irq_channel == 2'd0)
        else $error("irq channel set without irq");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // an accepted word produces a result while the receiver stays ready
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_ready ##1 out_ready |=> out_valid)
        else $error("result missing");

endmodule

bind four_channel_dma_controller fcdma_checker u_fcdma_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready), .out_data(out.data)
);

@@ tb/four_channel_dma_controller_test.sv @@
// four_channel_dma_controller_test: self-checking testbench for the dma controller
// depends on fcdma_pkg, fcdma_if and four_channel_dma_controller
`timescale 1ns / 100ps

module four_channel_dma_controller_test;
    import fcdma_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_data;
    int errors;
    int word_count;
    int stall_pct;

    fcdma_if #(.payload_t(req_t)) req_ch ();
    fcdma_if #(.payload_t(rsp_t)) rsp_ch ();

    four_channel_dma_controller uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in(req_ch.sink), .out(rsp_ch.source)
    );

    // predictor state
    logic        sel;
    logic [27:0] src_reg [4];
    logic [27:0] dst_reg [4];
    logic [31:0] ctl_reg [4];
    logic [31:0] src_cur [4];
    logic [31:0] dst_cur [4];
    logic [20:0] left [4];
    logic [3:0]  act;
    logic [6:0]  burst;
    logic [1:0]  cur;
    logic        busy;
    rsp_t        expected_q [$];

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [2:0] mode_of(logic [31:0] c);
        return c[29:27];
    endfunction

    // control register write with abort and load of cursors
    function automatic void predict_ctl(logic [1:0] ch, logic [31:0] m, logic [31:0] v,
                                        logic f);
        logic [31:0] prev;
        logic [31:0] now;
        prev = ctl_reg[ch];
        if (sel)
            m &= (ch == 2'd3) ? CTL_MASK_RED3 : CTL_MASK_RED;
        now = (prev & ~m) | (v & m);
        ctl_reg[ch] = now;
        if (!now[31] || mode_of(now) != mode_of(prev))
        begin
            act[ch] = 1'b0;
            if (busy && cur == ch)
                busy = 1'b0;
        end
        if (now[31] && mode_of(now) == MODE_FIFO && f)
            act[ch] = 1'b1;
        if (!prev[31] && now[31])
        begin
            dst_cur[ch] = {4'd0, dst_reg[ch]};
            src_cur[ch] = {4'd0, src_reg[ch]};
            left[ch] = now[20:0];
            if (mode_of(now) == MODE_IMMEDIATE)
                act[ch] = 1'b1;
        end
    endfunction

    // one unit of service for the current or lowest active channel
    function automatic void predict_step(logic f, inout rsp_t r);
        logic [31:0] c;
        logic [2:0]  md;
        logic [1:0]  ds;
        logic [1:0]  ss;
        logic [31:0] sz;
        logic [1:0]  ch;
        int i;
        if (!busy)
        begin
            for (i = 0; i < 4; i++)
                if (act[i])
                    break;
            if (i >= 4)
                return;
            act[i] = 1'b0;
            cur = i[1:0];
            burst = '0;
            busy = 1'b1;
        end
        ch = cur;
        c = ctl_reg[ch];
        md = mode_of(c);
        ds = c[22:21];
        ss = c[24:23];
        sz = c[26] ? 32'd4 : 32'd2;
        if (left[ch] != 0)
        begin
            r.copy_valid = 1'b1;
            r.copy_source = src_cur[ch];
            r.copy_dest = dst_cur[ch];
            r.copy_is_word = c[26];
            if (ss == 2'd0) src_cur[ch] += sz;
            else if (ss == 2'd1) src_cur[ch] -= sz;
            if (ds == 2'd0 || ds == 2'd3) dst_cur[ch] += sz;
            else if (ds == 2'd1) dst_cur[ch] -= sz;
            left[ch] = left[ch] - 21'd1;
            if (md == MODE_FIFO)
                burst = burst + 7'd1;
            if (left[ch] != 0 && !(md == MODE_FIFO && burst >= 7'(DEF_FIFO_BURST)))
                return;
        end
        busy = 1'b0;
        if (md == MODE_FIFO)
        begin
            if (f)
                act[ch] = 1'b1;
            if (left[ch] != 0)
                return;
        end
        if (c[25] && md != MODE_IMMEDIATE)
        begin
            left[ch] = c[20:0];
            if (ds == 2'd3)
                dst_cur[ch] = {4'd0, dst_reg[ch]};
        end
        else
        begin
            ctl_reg[ch] = c & ~32'h8000_0000;
            act[ch] = 1'b0;
        end
        if (c[30])
        begin
            r.irq_valid = 1'b1;
            r.irq_channel = ch;
        end
    endfunction

    // expected result of one request word
    function automatic rsp_t dma_predict(req_t q);
        rsp_t r;
        logic [31:0] m;
        r = '0;
        m = q.write_mask;
        case (q.operation)
            OP_WR_SRC:
            begin
                m &= (!sel || q.channel != 2'd0) ? ADDR_MASK_FULL : ADDR_MASK_RED;
                src_reg[q.channel] = (src_reg[q.channel] & ~m[27:0])
                    | (q.write_value[27:0] & m[27:0]);
            end
            OP_WR_DST:
            begin
                m &= (!sel || q.channel == 2'd3) ? ADDR_MASK_FULL : ADDR_MASK_RED;
                dst_reg[q.channel] = (dst_reg[q.channel] & ~m[27:0])
                    | (q.write_value[27:0] & m[27:0]);
            end
            OP_WR_CTL:
                predict_ctl(q.channel, m, q.write_value, q.fifo_half_empty);
            OP_TRIGGER, OP_DISABLE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    // doubled mode: modes above 3 can never match
                    if (q.channel_set[i] && ctl_reg[i][31] && !(sel && q.event_mode > 3'd3)
                        && mode_of(ctl_reg[i]) ==
                           (sel ? {q.event_mode[1:0], 1'b0} : q.event_mode))
                        act[i] = (q.operation == OP_TRIGGER);
                end
            end
            OP_STEP:
                predict_step(q.fifo_half_empty, r);
            default:
                ;
        endcase
        r.active_channels = act;
        return r;
    endfunction

    // send one word, predicting at acceptance
    task automatic send_word(req_t q);
        if ($urandom_range(99) < stall_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= q;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        expected_q.push_back(dma_predict(q));
        word_count++;
        @(negedge clk);
    endtask

    task automatic drain;
        req_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_cpu(logic v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        sel = v;
    endtask

    function automatic req_t make_req(logic [2:0] op, logic [1:0] ch, logic [31:0] m,
                                      logic [31:0] v, logic [2:0] em, logic [3:0] cs, logic f);
        req_t q;
        q.operation = op;
        q.channel = ch;
        q.write_mask = m;
        q.write_value = v;
        q.event_mode = em;
        q.channel_set = cs;
        q.fifo_half_empty = f;
        return q;
    endfunction

    function automatic req_t rand_req();
        return make_req(3'($urandom_range(7)), 2'($urandom_range(3)), $urandom, $urandom,
                        3'($urandom_range(7)), 4'($urandom_range(15)),
                        1'($urandom_range(1)));
    endfunction

    // set up one channel and run it with a few steps
    task automatic run_channel(logic [1:0] ch, logic [31:0] ctl, int steps);
        send_word(make_req(OP_WR_SRC, ch, '1, $urandom, '0, '0, 1'b0));
        send_word(make_req(OP_WR_DST, ch, '1, $urandom, '0, '0, 1'b0));
        send_word(make_req(OP_WR_CTL, ch, '1, ctl, '0, '0, 1'($urandom_range(1))));
        if (ctl[29:27] != MODE_IMMEDIATE)
            send_word(make_req(OP_TRIGGER, 2'd0, '0, '0,
                      sel ? {1'b0, ctl[29:28]} : ctl[29:27], 4'hF, 1'b0));
        repeat (steps)
            send_word(make_req(OP_STEP, 2'd0, '0, '0, '0, '0, 1'($urandom_range(1))));
    endtask

    // directed: field extremes, all operations, special cases
    task automatic test_directed;
        send_word(make_req(OP_WR_SRC, 2'd0, '1, '1, '0, '0, 1'b0));
        send_word(make_req(OP_WR_DST, 2'd3, '1, '1, '0, '0, 1'b0));
        send_word(make_req(3'd6, 2'd1, '1, '1, 3'd7, 4'd15, 1'b1));
        send_word(make_req(3'd7, 2'd2, '0, '0, '0, '0, 1'b0));
        send_word(make_req(OP_STEP, 2'd0, '0, '0, '0, '0, 1'b0));
        // zero count with irq
        run_channel(2'd1, 32'hC000_0000, 2);
        // word unit, decrement both, count 3
        run_channel(2'd0, 32'hC4A0_0003, 4);
        // fixed addresses, halfword
        run_channel(2'd2, 32'h8140_0002, 3);
        // repeat with reload in mode 1
        run_channel(2'd3, 32'hCE68_0002, 5);
        send_word(make_req(OP_DISABLE, 2'd0, '0, '0, 3'd1, 4'hF, 1'b0));
        // control write abort in progress
        run_channel(2'd0, 32'h8000_0005, 2);
        send_word(make_req(OP_WR_CTL, 2'd0, '1, 32'h0000_0005, '0, '0, 1'b0));
        send_word(make_req(OP_STEP, 2'd0, '0, '0, '0, '0, 1'b0));
    endtask

    // fifo mode burst limit and re-arm
    task automatic test_fifo_burst;
        run_channel(2'd2, 32'hF800_0100, 130);
        repeat (140)
            send_word(make_req(OP_STEP, 2'd0, '0, '0, '0, '0, 1'b1));
        send_word(make_req(OP_WR_CTL, 2'd2, '1, '0, '0, '0, 1'b0));
    endtask

    // random sequences of well-formed setups plus noise
    task automatic test_random(int n);
        int i;
        logic [31:0] c;
        logic [1:0] ch;
        i = 0;
        while (i < n)
        begin
            if ($urandom_range(99) < 60)
            begin
                c = $urandom;
                c[31] = 1'b1;
                c[20:0] = 21'($urandom_range(0, 6));
                if ($urandom_range(3) == 0)
                    c[29:27] = MODE_IMMEDIATE;
                ch = 2'($urandom_range(3));
                // clear enable first so the load happens
                send_word(make_req(OP_WR_CTL, ch, '1, '0, '0, '0, 1'b0));
                run_channel(ch, c, $urandom_range(1, 8));
                i += 12;
            end
            else
            begin
                send_word(rand_req());
                i++;
            end
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        rsp_t a;
        rsp_t e;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            a = rsp_ch.data;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result word");
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (a.copy_valid !== e.copy_valid)
                begin
                    $error("copy_valid exp %0h got %0h", e.copy_valid, a.copy_valid);
                    errors++;
                end
                if (a.copy_source !== e.copy_source)
                begin
                    $error("copy_source exp %0h got %0h", e.copy_source, a.copy_source);
                    errors++;
                end
                if (a.copy_dest !== e.copy_dest)
                begin
                    $error("copy_dest exp %0h got %0h", e.copy_dest, a.copy_dest);
                    errors++;
                end
                if (a.copy_is_word !== e.copy_is_word)
                begin
                    $error("copy_is_word exp %0h got %0h", e.copy_is_word, a.copy_is_word);
                    errors++;
                end
                if (a.irq_valid !== e.irq_valid)
                begin
                    $error("irq_valid exp %0h got %0h", e.irq_valid, a.irq_valid);
                    errors++;
                end
                if (a.irq_channel !== e.irq_channel)
                begin
                    $error("irq_channel exp %0h got %0h", e.irq_channel, a.irq_channel);
                    errors++;
                end
                if (a.active_channels !== e.active_channels)
                begin
                    $error("active_channels exp %0h got %0h",
                           e.active_channels, a.active_channels);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

    // watchdog
    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        errors = 0;
        word_count = 0;
        stall_pct = 9;
        sel = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            src_reg[i] = '0; dst_reg[i] = '0; ctl_reg[i] = '0;
            src_cur[i] = '0; dst_cur[i] = '0; left[i] = '0;
        end
        act = '0; burst = '0; cur = '0; busy = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        set_cpu(1'b0);
        test_directed();
        test_fifo_burst();
        set_cpu(1'b1);
        test_directed();
        test_random(80);
        // stretch with no idling
        stall_pct = 0;
        test_random(60);
        stall_pct = 9;
        set_cpu(1'b0);
        test_random(110);
        drain();
        repeat (10) @(negedge clk);
        $display("covered %0d request words over both cpu selections", word_count);
        $display("including fifo bursts, repeat reloads, aborts and events");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
